>>> design/rpn_pkg.sv
// Package: stack sizing, data width, action and status codes for the RPN calculator.
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ITER_W      = $clog2(DATA_W);

   typedef enum logic [2:0] {
      ACT_PUSH  = 3'd0,
      ACT_ADD   = 3'd1,
      ACT_SUB   = 3'd2,
      ACT_MUL   = 3'd3,
      ACT_DIV   = 3'd4,
      ACT_SWAP  = 3'd5,
      ACT_CLEAR = 3'd6,
      ACT_SHOW  = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OVER    = 3'd1,
      ST_UNDER   = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_EMPTY   = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

endpackage

>>> design/rpn_stack_integer_alu_top.sv
// Top level: RPN integer calculator with the stack held in a synchronous RAM.
//
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle while rsp_valid is high, and the receiver
// cannot stall it. The whole stack lives in a RAM with registered read data
// and a copy of the top entry sits in a register, so each item is a short
// read-modify-write sequence. Push, clear, show top and S_EXEC errors end
// in S_EXEC; add, subtract and multiply go on to S_OPER; swap to S_SWAP2;
// a binary error that must refetch the new top to S_RELOAD; divide to
// S_DIV_WAIT for the divider. busy drops in the strobe cycle, so the next
// transfer may land there. Stack entries need no clearing after reset.
module rpn_stack_integer_alu_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_action,
   input  logic signed [31:0]          req_operand_value,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic signed [31:0]          rsp_top_value,
   output logic                        rsp_top_valid,
   output logic [4:0]                  rsp_stack_depth
);
   import rpn_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_OPER,
      S_DIV_WAIT,
      S_SWAP2,
      S_RELOAD
   } state_type;

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [DATA_W-1:0] mem_rdata;

   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quo;

   logic [DATA_W:0]   sum;
   logic              fin_ok;
   logic              fin_err;
   status_type        fin_status;
   logic [DATA_W-1:0] fin_res;

   rpn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mem_rdata),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      val_in       = val_ff;
      top_in       = top_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(count_ff - CNT_W'(2));
      mem_wdata    = top_ff;
      mem_raddr    = ADDR_W'(count_ff - CNT_W'(2));
      div_start    = 1'b0;
      fin_ok       = 1'b0;
      fin_err      = 1'b0;
      fin_status   = ST_OK;
      fin_res      = top_ff;
      sum          = {top_ff[DATA_W-1], top_ff} + {mem_rdata[DATA_W-1], mem_rdata};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in   = action_type'(req_action);
               val_in   = req_operand_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            case (act_ff)
               ACT_PUSH: begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[ADDR_W-1:0];
                     mem_wdata = val_ff;
                     top_in    = val_ff;
                     count_in  = count_ff + 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SWAP: begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in    = ST_EMPTY;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_OPER;
                  end
               end
               ACT_CLEAR: begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_OPER: begin
            case (act_ff)
               ACT_SWAP: begin
                  mem_we    = 1'b1;
                  mem_waddr = ADDR_W'(count_ff - CNT_W'(1));
                  mem_wdata = mem_rdata;
                  top_in    = mem_rdata;
                  val_in    = top_ff;
                  state_in  = S_SWAP2;
               end
               ACT_ADD: begin
                  if (sum[DATA_W] != sum[DATA_W-1]) begin
                     fin_err    = 1'b1;
                     fin_status = sum[DATA_W] ? ST_UNDER : ST_OVER;
                  end else begin
                     fin_ok  = 1'b1;
                     fin_res = sum[DATA_W-1:0];
                  end
               end
               ACT_SUB: begin
                  fin_ok  = 1'b1;
                  fin_res = top_ff - mem_rdata;
               end
               ACT_MUL: begin
                  fin_ok  = 1'b1;
                  fin_res = top_ff * mem_rdata;
               end
               default: begin
                  if (top_ff == '0) begin
                     fin_err    = 1'b1;
                     fin_status = ST_DIVZERO;
                  end else if (top_ff == '1 &&
                               mem_rdata == {1'b1, {(DATA_W-1){1'b0}}}) begin
                     fin_err    = 1'b1;
                     fin_status = ST_OVER;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV_WAIT;
                  end
               end
            endcase
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               fin_ok  = 1'b1;
               fin_res = div_quo;
            end
         end
         S_SWAP2: begin
            mem_we       = 1'b1;
            mem_waddr    = ADDR_W'(count_ff - CNT_W'(2));
            mem_wdata    = val_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_RELOAD: begin
            top_in       = mem_rdata;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_ok) begin
         mem_we       = 1'b1;
         mem_waddr    = ADDR_W'(count_ff - CNT_W'(2));
         mem_wdata    = fin_res;
         top_in       = fin_res;
         count_in     = count_ff - CNT_W'(1);
         status_in    = ST_OK;
         rsp_valid_in = 1'b1;
         state_in     = S_IDLE;
      end
      if (fin_err) begin
         count_in  = count_ff - CNT_W'(2);
         status_in = fin_status;
         if (count_ff != CNT_W'(2)) begin
            mem_raddr = ADDR_W'(count_ff - CNT_W'(3));
            state_in  = S_RELOAD;
         end else begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      val_ff <= val_in;
      top_ff <= top_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_top_valid   = (count_ff != '0);
   assign rsp_top_value   = (count_ff != '0) ? top_ff : '0;
   assign rsp_stack_depth = 5'(count_ff);

endmodule

>>> design/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> design/rpn_div.sv
// Iterative signed divider: one quotient bit per cycle, truncates toward zero.
module rpn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rpn_pkg::DATA_W-1:0]  dividend,
   input  logic [rpn_pkg::DATA_W-1:0]  divisor,
   output logic                        done,
   output logic [rpn_pkg::DATA_W-1:0]  quotient
);
   import rpn_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      trial   = shifted - {1'b0, dmag_ff};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         iter_in = '0;
         dmag_in = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule
